### design/sitda_pkg.sv
`timescale 1ns / 1ps

package sitda_pkg;

  // one bcd digit
  typedef logic [3:0] digit_t;

  // ascii codes used in the spelling
  localparam logic [6:0] ASCII_ZERO  = 7'd48;
  localparam logic [6:0] ASCII_MINUS = 7'd45;

  // control shared by every digit cell
  typedef struct packed {
    logic clear;        // zero the digit
    logic dabble;       // add-3 and shift one binary bit in
    logic digit_shift;  // take the lower neighbor's digit
  } cell_ctl_t;

endpackage

### design/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// channel  | ports                          | handshake
// ---------+--------------------------------+-----------------------------
// input    | in_value                       | start high while busy low
// result   | out_character, out_last        | out_valid, one cycle each
//
// an item is accepted, converted, given a minus sign if negative, then shifted out
// digit by digit; at VALUE_BITS = 32 the row holds NDIG = 10 digits.
// the bcd cell row takes one binary bit per cycle, then shifts out one digit
// per cycle, leading zeros included.
// reset (synchronous, rst_n low) returns the sequencer to idle.
// results cannot be stalled; each one is shown for exactly one cycle.

module signed_int_to_decimal_ascii
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  output logic [6:0]            out_character,
  output logic                  out_last
);

  // digit count of the largest magnitude
  localparam int NDIG   = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCW    = $clog2(VALUE_BITS);
  localparam int DCW    = $clog2(NDIG + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [BCW-1:0]       bit_cnt_r, bit_cnt_nxt;
  logic [DCW-1:0]       dig_left_r, dig_left_nxt;
  logic                 neg_r, neg_nxt;
  logic                 started_r, started_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [6:0]           out_character_r, out_character_nxt;
  logic                 out_last_r, out_last_nxt;

  cell_ctl_t            ctl;
  logic [NDIG-1:0]      carry;
  digit_t               dig [NDIG];
  digit_t               top_digit;
  logic                 accept;
  logic                 in_neg;
  logic [VALUE_BITS-1:0] in_mag;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign top_digit = dig[NDIG-1];

  // magnitude of the incoming value, exact for the most negative one
  assign in_neg = in_value[VALUE_BITS-1];
  assign in_mag = in_neg ? (~in_value) + VALUE_BITS'(1) : in_value;

  // row of bcd cells, least significant digit at index 0
  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    logic   sin;
    digit_t din;
    if (i == 0) begin : g_low
      assign sin = mag_r[VALUE_BITS-1];
      assign din = '0;
    end else begin : g_mid
      assign sin = carry[i-1];
      assign din = dig[i-1];
    end
    sitda_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .shift_in  (sin),
      .digit_in  (din),
      .carry_out (carry[i]),
      .digit_out (dig[i])
    );
  end

  // sequencer
  always_comb begin
    state_nxt         = state_r;
    mag_nxt           = mag_r;
    bit_cnt_nxt       = bit_cnt_r;
    dig_left_nxt      = dig_left_r;
    neg_nxt           = neg_r;
    started_nxt       = started_r;
    out_valid_nxt     = 1'b0;
    out_character_nxt = out_character_r;
    out_last_nxt      = 1'b0;
    ctl               = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mag_nxt      = in_mag;
          neg_nxt      = in_neg;
          bit_cnt_nxt  = BCW'(VALUE_BITS - 1);
          dig_left_nxt = DCW'(NDIG);
          started_nxt  = 1'b0;
          ctl.clear    = 1'b1;
          state_nxt    = ST_CONV;
        end
      end
      ST_CONV: begin
        ctl.dabble  = 1'b1;
        mag_nxt     = {mag_r[VALUE_BITS-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - BCW'(1);
        if (bit_cnt_r == '0) begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        out_valid_nxt     = 1'b1;
        out_character_nxt = ASCII_MINUS;
        state_nxt         = ST_EMIT;
      end
      ST_EMIT: begin
        ctl.digit_shift = 1'b1;
        dig_left_nxt    = dig_left_r - DCW'(1);
        // leading zeros are dropped, the units digit always goes out
        if (started_r || top_digit != '0 || dig_left_r == DCW'(1)) begin
          out_valid_nxt     = 1'b1;
          out_character_nxt = ASCII_ZERO + {3'b000, top_digit};
          out_last_nxt      = (dig_left_r == DCW'(1));
          started_nxt       = 1'b1;
        end
        if (dig_left_r == DCW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    mag_r           <= mag_nxt;
    bit_cnt_r       <= bit_cnt_nxt;
    dig_left_r      <= dig_left_nxt;
    neg_r           <= neg_nxt;
    started_r       <= started_nxt;
    out_character_r <= out_character_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

endmodule

### design/sitda_cell.sv
`timescale 1ns / 1ps

module sitda_cell
  import sitda_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      shift_in,
  input  digit_t    digit_in,
  output logic      carry_out,
  output digit_t    digit_out
);

  digit_t digit_r;
  digit_t digit_nxt;
  digit_t adj;

  // add 3 when the digit would overflow after doubling
  always_comb begin
    adj       = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
    carry_out = adj[3];
  end

  // next digit by mode
  always_comb begin
    priority if (ctl.clear) begin
      digit_nxt = '0;
    end else if (ctl.dabble) begin
      digit_nxt = {adj[2:0], shift_in};
    end else if (ctl.digit_shift) begin
      digit_nxt = digit_in;
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit_out = digit_r;

endmodule
